/* rtl/assert_macros.svh */
// Assertion macros for the RTL file that carries checks.
// Both macros expect clk and rst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("concurrent assertion failed");
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

/* rtl/shs_pkg.sv */
`default_nettype none

package shs_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FILL_W   = 6;
  localparam int unsigned ROUND_W  = 6;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned LEN_W    = 64;
  localparam int unsigned BLKCNT_W = LEN_W - FILL_W - 3;
  localparam int unsigned WIN_W    = 512;

  localparam logic [1:0] BSEL_IN   = 2'd0;
  localparam logic [1:0] BSEL_MARK = 2'd1;
  localparam logic [1:0] BSEL_ZERO = 2'd2;
  localparam logic [1:0] BSEL_LEN  = 2'd3;

  localparam logic [BYTE_W-1:0] PAD_MARK     = 8'h80;
  localparam logic [FILL_W-1:0] FILL_LEN_POS = 6'd56;
  localparam logic [FILL_W-1:0] FILL_LAST    = 6'd63;
  localparam logic [ROUND_W-1:0] ROUND_LAST  = 6'd63;
  localparam logic [IDX_W-1:0] IDX_LAST      = 3'd7;

  localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic                shift;
    logic [1:0]          byte_sel;
    logic                len_snap;
    logic                cload;
    logic                round;
    logic [ROUND_W-1:0]  round_idx;
    logic                cadd;
    logic                emit_load;
    logic [IDX_W-1:0]    emit_idx;
    logic                init;
  } shs_cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              out_free;
  } shs_sts_t;

  function automatic logic [WORD_W-1:0] round_const(input logic [ROUND_W-1:0] idx);
    logic [WORD_W-1:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* rtl/shs_in_if.sv */
`default_nettype none

interface shs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source(output valid, output data_byte, output byte_valid,
                 output end_of_message, input ready);
  modport sink(input valid, input data_byte, input byte_valid,
               input end_of_message, output ready);
endinterface

`default_nettype wire

/* rtl/shs_out_if.sv */
`default_nettype none

interface shs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source(output valid, output digest_word, output word_index,
                 output last_word, input ready);
  modport sink(input valid, input digest_word, input word_index,
               input last_word, output ready);
endinterface

`default_nettype wire

/* rtl/shs_datapath.sv */
`default_nettype none

module shs_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [7:0]       in_data_byte,
  input  wire shs_pkg::shs_cmd_t cmd,
  output shs_pkg::shs_sts_t     sts,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic [31:0]           out_digest_word,
  output logic [2:0]            out_word_index,
  output logic                  out_last_word
);
  import shs_pkg::*;

  function automatic logic [WORD_W-1:0] big_s0(input logic [WORD_W-1:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WORD_W-1:0] big_s1(input logic [WORD_W-1:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WORD_W-1:0] small_s0(input logic [WORD_W-1:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WORD_W-1:0] small_s1(input logic [WORD_W-1:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // The window holds the message block as bytes while it fills; during the rounds
  // word 0 at the top is the current schedule word and new words enter at the bottom.
  logic [WIN_W-1:0]    win_r;
  logic [WORD_W-1:0]   chain_r [8];
  logic [WORD_W-1:0]   v_r     [8];
  logic [FILL_W-1:0]   fill_r;
  logic [BLKCNT_W-1:0] blk_cnt_r;
  logic [LEN_W-1:0]    len_r;
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_word_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic                out_last_r;

  logic [BYTE_W-1:0] byte_src;
  logic [WORD_W-1:0] w0, w1, w9, w14, w_next;
  logic [WORD_W-1:0] t1, t2, ch, maj;

  assign w0  = win_r[WIN_W-1 -: WORD_W];
  assign w1  = win_r[WIN_W-1-WORD_W -: WORD_W];
  assign w9  = win_r[WIN_W-1-9*WORD_W -: WORD_W];
  assign w14 = win_r[WIN_W-1-14*WORD_W -: WORD_W];
  assign w_next = small_s1(w14) + w9 + small_s0(w1) + w0;

  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + big_s1(v_r[4]) + ch + round_const(cmd.round_idx) + w0;
  assign t2  = big_s0(v_r[0]) + maj;

  always_comb begin
    unique case (cmd.byte_sel)
      BSEL_IN:   byte_src = in_data_byte;
      BSEL_MARK: byte_src = PAD_MARK;
      BSEL_ZERO: byte_src = '0;
      BSEL_LEN:  byte_src = len_r[LEN_W-1 -: BYTE_W];
      default:   byte_src = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      win_r <= {win_r[WIN_W-BYTE_W-1:0], byte_src};
    end else if (cmd.round) begin
      win_r <= {win_r[WIN_W-WORD_W-1:0], w_next};
    end
    if (cmd.cload) begin
      v_r <= chain_r;
    end else if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
    if (cmd.len_snap) begin
      len_r <= {blk_cnt_r, fill_r, 3'b000};
    end else if (cmd.shift && cmd.byte_sel == BSEL_LEN) begin
      len_r <= {len_r[LEN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
    end
    if (cmd.emit_load) begin
      out_word_r <= chain_r[cmd.emit_idx];
      out_idx_r  <= cmd.emit_idx;
      out_last_r <= (cmd.emit_idx == IDX_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r     <= INIT_HASH;
      fill_r      <= '0;
      blk_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.shift) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.init) begin
        chain_r   <= INIT_HASH;
        blk_cnt_r <= '0;
      end else if (cmd.cadd) begin
        for (int i = 0; i < 8; i++) begin
          chain_r[i] <= chain_r[i] + v_r[i];
        end
        blk_cnt_r <= blk_cnt_r + 1'b1;
      end
      if (cmd.emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.fill     = fill_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

endmodule

`default_nettype wire

/* rtl/shs_ctrl.sv */
`default_nettype none

module shs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_byte_valid,
  input  wire logic              in_end,
  output logic                   in_ready,
  input  wire shs_pkg::shs_sts_t sts,
  output shs_pkg::shs_cmd_t      cmd
);
  import shs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLOAD = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_CADD  = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_ZERO  = 3'd5;
  localparam logic [2:0] S_LENB  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [2:0]         ret_r, ret_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic [IDX_W-1:0]   emit_idx_r, emit_idx_nxt;
  logic               block_full;

  assign block_full = (sts.fill == FILL_LAST);
  assign in_ready   = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    round_nxt    = round_r;
    emit_idx_nxt = emit_idx_r;
    cmd          = '0;
    cmd.round_idx = round_r;
    cmd.emit_idx  = emit_idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_byte_valid) begin
            cmd.shift    = 1'b1;
            cmd.byte_sel = BSEL_IN;
          end
          if (in_byte_valid && block_full) begin
            ret_nxt   = in_end ? S_MARK : S_IDLE;
            state_nxt = S_CLOAD;
          end else if (in_end) begin
            state_nxt = S_MARK;
          end
        end
      end
      S_MARK: begin
        cmd.shift    = 1'b1;
        cmd.byte_sel = BSEL_MARK;
        cmd.len_snap = 1'b1;
        if (block_full) begin
          ret_nxt   = S_ZERO;
          state_nxt = S_CLOAD;
        end else begin
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        if (sts.fill == FILL_LEN_POS) begin
          state_nxt = S_LENB;
        end else begin
          cmd.shift    = 1'b1;
          cmd.byte_sel = BSEL_ZERO;
          if (block_full) begin
            ret_nxt   = S_ZERO;
            state_nxt = S_CLOAD;
          end
        end
      end
      S_LENB: begin
        cmd.shift    = 1'b1;
        cmd.byte_sel = BSEL_LEN;
        if (block_full) begin
          ret_nxt   = S_EMIT;
          state_nxt = S_CLOAD;
        end
      end
      S_CLOAD: begin
        cmd.cload = 1'b1;
        round_nxt = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        round_nxt = round_r + 1'b1;
        if (round_r == ROUND_LAST) begin
          state_nxt = S_CADD;
        end
      end
      S_CADD: begin
        cmd.cadd  = 1'b1;
        state_nxt = ret_r;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          emit_idx_nxt  = emit_idx_r + 1'b1;
          if (emit_idx_r == IDX_LAST) begin
            cmd.init  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= S_IDLE;
      round_r    <= '0;
      emit_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      round_r    <= round_nxt;
      emit_idx_r <= emit_idx_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/sha256_stream_hasher.sv */
// Streaming SHA-256: one byte per transfer, digest as eight 32-bit words.
// A full 64-byte block holds off input during the 64 rounds of the single round
// unit plus load and chain update.
// End of message: padding, one or two compressions, then 8 words.
// Reset (rst_n low, synchronous) returns control and chaining to initial values.
`default_nettype none
`include "assert_macros.svh"

module sha256_stream_hasher (
  input wire logic clk,
  input wire logic rst_n,
  shs_in_if.sink   in_chan,
  shs_out_if.source out_chan
);
  import shs_pkg::*;

  shs_cmd_t cmd;
  shs_sts_t sts;

  logic             out_mid_xfer;
  logic             len_shift;
  logic [IDX_W-1:0] step_idx;

  shs_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_chan.valid),
    .in_byte_valid (in_chan.byte_valid),
    .in_end        (in_chan.end_of_message),
    .in_ready      (in_chan.ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  shs_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_chan.data_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_digest_word (out_chan.digest_word),
    .out_word_index  (out_chan.word_index),
    .out_last_word   (out_chan.last_word)
  );

  assign out_mid_xfer = out_chan.valid && out_chan.ready && !out_chan.last_word;
  assign len_shift    = cmd.shift && (cmd.byte_sel == BSEL_LEN);
  assign step_idx     = out_chan.word_index + 3'd1;

  `ASSERT_NEVER(a_no_accept_while_emit, in_chan.ready && cmd.emit_load)
  `ASSERT_CLK(a_len_aligned, len_shift |-> (sts.fill >= FILL_LEN_POS))
  `ASSERT_CLK(a_words_in_order, out_mid_xfer |=> out_chan.valid && out_chan.word_index == $past(step_idx))

endmodule

`default_nettype wire

/* tb/sha256_digest_checker.sv */
`timescale 1ns / 100ps

module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  shs_in_if           in_mon,
  shs_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned words_waiting,
  output int unsigned words_checked
);

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] K256 [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [7:0]   msg_block [64];
  int unsigned  msg_fill;
  logic [63:0]  msg_bits;
  logic [31:0]  chain [8];
  digest_word_t digest_q [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void start_message();
    msg_fill = 0;
    msg_bits = '0;
    chain = IV256;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wr;
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] t1;
    logic [31:0] t2;
    for (int r = 0; r < 16; r++) begin
      w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
    end
    v = chain;
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        s0 = rotr(w[(r-15)%16], 7) ^ rotr(w[(r-15)%16], 18) ^ (w[(r-15)%16] >> 3);
        s1 = rotr(w[(r-2)%16], 17) ^ rotr(w[(r-2)%16], 19) ^ (w[(r-2)%16] >> 10);
        wr = s1 + w[(r-7)%16] + s0 + w[r%16];
        w[r%16] = wr;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + K256[r] + wr;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int r = 0; r < 8; r++) begin
      chain[r] = chain[r] + v[r];
    end
  endfunction

  function automatic void absorb_byte(input logic [7:0] data);
    msg_block[msg_fill] = data;
    msg_fill++;
    if (msg_fill == 64) begin
      compress_block();
      msg_bits = msg_bits + 64'd512;
      msg_fill = 0;
    end
  endfunction

  function automatic void finish_message();
    int unsigned  i;
    digest_word_t dw;
    msg_bits = msg_bits + 64'(msg_fill * 8);
    i = msg_fill;
    msg_block[i] = 8'h80;
    i++;
    if (i > 56) begin
      while (i < 64) begin
        msg_block[i] = 8'h00;
        i++;
      end
      compress_block();
      i = 0;
    end
    while (i < 56) begin
      msg_block[i] = 8'h00;
      i++;
    end
    for (int k = 0; k < 8; k++) begin
      msg_block[56 + k] = msg_bits[63 - 8*k -: 8];
    end
    compress_block();
    for (int k = 0; k < 8; k++) begin
      dw.word = chain[k];
      dw.index = 3'(k);
      dw.last = (k == 7);
      digest_q.push_back(dw);
    end
    start_message();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
    fail_count++;
  endtask

  task automatic check_word();
    digest_word_t dw;
    if (digest_q.size() == 0) begin
      report_mismatch("digest word with nothing outstanding", '0, out_mon.digest_word);
    end else begin
      dw = digest_q.pop_front();
      if (out_mon.digest_word !== dw.word) begin
        report_mismatch("digest_word", dw.word, out_mon.digest_word);
      end
      if (out_mon.word_index !== dw.index) begin
        report_mismatch("word_index", 32'(dw.index), 32'(out_mon.word_index));
      end
      if (out_mon.last_word !== dw.last) begin
        report_mismatch("last_word", 32'(dw.last), 32'(out_mon.last_word));
      end
    end
    words_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_message();
      digest_q.delete();
      fail_count = 0;
      words_checked = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        check_word();
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.byte_valid) begin
          absorb_byte(in_mon.data_byte);
        end
        if (in_mon.end_of_message) begin
          finish_message();
        end
      end
    end
    words_waiting = digest_q.size();
  end

endmodule

/* tb/sha256_stream_hasher_tb.sv */
`timescale 1ns / 100ps

module sha256_stream_hasher_tb;

  localparam int unsigned ITEM_TARGET  = 410;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned HOLD_AFTER   = 120;
  localparam int unsigned PAD_EDGE_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 128};

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned two_pad_msgs = 0;
  bit          src_calm;
  bit          snk_calm;
  bit          sink_held;
  int unsigned fail_count;
  int unsigned words_waiting;
  int unsigned words_checked;

  shs_in_if  in_chan();
  shs_out_if out_chan();

  sha256_stream_hasher i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sha256_digest_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .words_waiting (words_waiting),
    .words_checked (words_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit of %0d.", CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] data, input logic bv, input logic eom);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data_byte <= data;
    in_chan.byte_valid <= bv;
    in_chan.end_of_message <= eom;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    bit tie_end;
    tie_end = (len != 0) && ($urandom_range(0, 1) == 1);
    src_calm = ($urandom_range(0, 3) == 0);
    for (int unsigned n = 0; n < len; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(8'($urandom), 1'b0, 1'b0);
      end
      send_item(8'($urandom), 1'b1, tie_end && (n == len - 1));
    end
    if (!tie_end) begin
      send_item(8'($urandom), 1'b0, 1'b1);
    end
    if (len % 64 >= 56) begin
      two_pad_msgs++;
    end
  endtask

  initial begin
    int unsigned stall;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = snk_calm ? 0 : $urandom_range(0, 3);
      if (sink_held || stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (sink_held) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      if (out_chan.last_word) begin
        snk_calm = ($urandom_range(0, 3) == 0);
      end
    end
  end

  // The receiver stops for a long stretch while bytes keep coming, so the
  // pending digest backs up and the input side has to stall.
  initial begin
    sink_held = 1'b0;
    wait (items_sent >= HOLD_AFTER);
    @(negedge clk);
    while (!(out_chan.valid && !out_chan.last_word)) @(negedge clk);
    sink_held = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    @(negedge clk);
    sink_held = 1'b0;
  end

  initial begin
    int unsigned sel;
    int unsigned len;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.data_byte <= 8'h00;
    in_chan.byte_valid <= 1'b0;
    in_chan.end_of_message <= 1'b0;
    src_calm = 1'b0;
    snk_calm = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 19);
      if (sel < 10) begin
        len = $urandom_range(0, 8);
      end else if (sel < 17) begin
        len = PAD_EDGE_LENS[$urandom_range(0, 7)];
      end else begin
        len = $urandom_range(0, 130);
      end
      if (len > ITEM_TARGET - items_sent) begin
        len = ITEM_TARGET - items_sent;
      end
      send_message(len);
    end
    in_chan.valid <= 1'b0;
    @(posedge clk);

    while (words_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input transfers, %0d digest words (%0d messages).",
             items_sent, words_checked, words_checked / 8);
    $display("Messages needing a second padding block: %0d; one receiver hold of %0d cycles.",
             two_pad_msgs, HOLD_CYCLES);
    if (fail_count == 0 && words_waiting == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
